// ===== sv/mcr_pkg.sv =====
// Shared constants and types of the midpoint circle rasterizer.
package mcr_pkg;

  localparam int SCREEN_W = 640;
  localparam int SCREEN_H = 480;

  // Widths of the input and result fields.
  localparam int ORG_W   = 12;
  localparam int RAD_W   = 10;
  localparam int COLOR_W = 16;
  localparam int IDX_W   = 19;

  // Internal state widths.
  localparam int STEP_W = 11;
  localparam int DEC_W  = 16;

  // Signed width that holds any center plus or minus any step offset.
  localparam int CRD_W = 14;

  // Number of symmetric points per step.
  localparam int NPTS = 8;

  // Widths of an on-screen column and row.
  localparam int XW = $clog2(SCREEN_W);
  localparam int YW = $clog2(SCREEN_H);

  // Width of row * SCREEN_W + column before it is cut to the index width.
  localparam int SUM_W  = YW + XW + 1;
  localparam int PROD_W = (SUM_W > IDX_W) ? SUM_W : IDX_W;

  // Depth of the queue between the front and the back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Input action codes.
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  // One classified item: the on-screen mask and the clipped coordinates.
  // An empty mask stands for a single result that writes nothing.
  typedef struct packed {
    logic [NPTS-1:0]         mask;
    logic [NPTS-1:0][XW-1:0] px;
    logic [NPTS-1:0][YW-1:0] py;
    logic [COLOR_W-1:0]      color;
    logic                    done;
  } job_t;

  // Handshake between the queue and the back.
  typedef struct packed {
    logic valid;
    job_t job;
  } head_t;

endpackage

// ===== sv/mcr_if.sv =====
// Stream interfaces for the command and pixel channels of the rasterizer.
interface mcr_cmd_if
  import mcr_pkg::*;
  ;
  logic                    valid;
  logic                    ready;
  logic                    action;
  logic signed [ORG_W-1:0] cen_x;
  logic signed [ORG_W-1:0] cen_y;
  logic [RAD_W-1:0]        radius;
  logic [COLOR_W-1:0]      pixel_color;

  modport source (
    output valid, action, cen_x, cen_y, radius, pixel_color,
    input  ready
  );
  modport sink (
    input  valid, action, cen_x, cen_y, radius, pixel_color,
    output ready
  );
endinterface

interface mcr_pix_if
  import mcr_pkg::*;
  ;
  logic               valid;
  logic               ready;
  logic               write_valid;
  logic [IDX_W-1:0]   pixel_index;
  logic [COLOR_W-1:0] write_color;
  logic               last;
  logic               done_res;

  modport source (
    output valid, write_valid, pixel_index, write_color, last, done_res,
    input  ready
  );
  modport sink (
    input  valid, write_valid, pixel_index, write_color, last, done_res,
    output ready
  );
endinterface

// ===== sv/mcr_front.sv =====
// Front of the rasterizer: holds the circle state and classifies each command.
module mcr_front
  import mcr_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  mcr_cmd_if.sink cmd,
  input  logic   full,
  output logic   push,
  output job_t   job
);

  localparam logic signed [CRD_W-1:0] W_LIM = CRD_W'(SCREEN_W);
  localparam logic signed [CRD_W-1:0] H_LIM = CRD_W'(SCREEN_H);

  logic signed [ORG_W-1:0] origin_x;
  logic signed [ORG_W-1:0] origin_y;
  logic [STEP_W-1:0]       step_x;
  logic [STEP_W-1:0]       step_y;
  logic signed [DEC_W-1:0] decision;
  logic [COLOR_W-1:0]      draw_color;
  logic                    active;

  logic [STEP_W-1:0]       step_x_next;
  logic [STEP_W-1:0]       step_y_next;
  logic signed [DEC_W-1:0] decision_next;
  logic                    done_step;

  logic signed [CRD_W-1:0] cx, cy, ox, oy;
  logic signed [CRD_W-1:0] ptx [NPTS];
  logic signed [CRD_W-1:0] pty [NPTS];
  logic [NPTS-1:0]         on_screen;

  logic signed [DEC_W-1:0] x16, y16;
  logic signed [STEP_W:0]  xn12, yn12;

  assign cmd.ready = !full;
  assign push      = cmd.valid && !full;

  // Eight octant points of the current step, in the fixed emission order.
  always_comb begin
    cx = CRD_W'(origin_x);
    cy = CRD_W'(origin_y);
    ox = $signed({{(CRD_W-STEP_W){1'b0}}, step_x});
    oy = $signed({{(CRD_W-STEP_W){1'b0}}, step_y});
    ptx[0] = cx + ox; pty[0] = cy + oy;
    ptx[1] = cx - ox; pty[1] = cy + oy;
    ptx[2] = cx + ox; pty[2] = cy - oy;
    ptx[3] = cx - ox; pty[3] = cy - oy;
    ptx[4] = cx + oy; pty[4] = cy + ox;
    ptx[5] = cx - oy; pty[5] = cy + ox;
    ptx[6] = cx + oy; pty[6] = cy - ox;
    ptx[7] = cx - oy; pty[7] = cy - ox;
    for (int i = 0; i < NPTS; i++) begin
      on_screen[i] = (ptx[i] >= 0) && (ptx[i] < W_LIM) &&
                     (pty[i] >= 0) && (pty[i] < H_LIM);
    end
  end

  // Decision term update; the row steps down when the term is not negative.
  always_comb begin
    x16 = $signed({{(DEC_W-STEP_W){1'b0}}, step_x});
    y16 = $signed({{(DEC_W-STEP_W){1'b0}}, step_y});
    if (decision < 0) begin
      decision_next = decision + (x16 <<< 2) + DEC_W'(6);
      step_y_next   = step_y;
    end else begin
      decision_next = decision + ((x16 - y16) <<< 2) + DEC_W'(10);
      step_y_next   = step_y - STEP_W'(1);
    end
    step_x_next = step_x + STEP_W'(1);
    xn12 = $signed({1'b0, step_x}) + (STEP_W+1)'(1);
    yn12 = (decision < 0) ? $signed({1'b0, step_y}) :
                            $signed({1'b0, step_y}) - (STEP_W+1)'(1);
    done_step = xn12 > yn12;
  end

  always_comb begin
    for (int i = 0; i < NPTS; i++) begin
      job.px[i] = ptx[i][XW-1:0];
      job.py[i] = pty[i][YW-1:0];
    end
    job.color = draw_color;
    if (cmd.action == ACT_START) begin
      job.mask = '0;
      job.done = 1'b0;
    end else if (!active) begin
      job.mask = '0;
      job.done = 1'b1;
    end else begin
      job.mask = on_screen;
      job.done = done_step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x   <= '0;
      origin_y   <= '0;
      step_x     <= '0;
      step_y     <= '0;
      decision   <= '0;
      draw_color <= '0;
      active     <= 1'b0;
    end else if (push) begin
      if (cmd.action == ACT_START) begin
        origin_x   <= cmd.cen_x;
        origin_y   <= cmd.cen_y;
        step_x     <= '0;
        step_y     <= STEP_W'(cmd.radius);
        decision   <= DEC_W'(3) - (DEC_W'(cmd.radius) <<< 1);
        draw_color <= cmd.pixel_color;
        active     <= 1'b1;
      end else if (active) begin
        step_x   <= step_x_next;
        step_y   <= step_y_next;
        decision <= decision_next;
        if (done_step) begin
          active <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== sv/mcr_queue.sv =====
// Short queue of classified items between the front and the back.
module mcr_queue
  import mcr_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  job_t  push_job,
  output logic  full,
  input  logic  pop,
  output head_t head
);

  job_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = count == QCNT_W'(QDEPTH);
  assign head.valid = count != '0;
  assign head.job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count beyond its depth");

endmodule

// ===== sv/mcr_back.sv =====
// Back: walks the kept points of each item, one pixel write a cycle unless pix stalls.
module mcr_back
  import mcr_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  head_t    head,
  output logic     pop,
  mcr_pix_if.source pix
);

  logic [NPTS-1:0] rem;
  logic            started;

  logic [NPTS-1:0]   cur_mask;
  logic [NPTS-1:0]   low;
  logic [NPTS-1:0]   mask_left;
  logic [XW-1:0]     sel_x;
  logic [YW-1:0]     sel_y;
  logic [PROD_W-1:0] prod;
  logic              emit;
  logic              has_point;

  logic               out_valid;
  logic               out_write;
  logic [IDX_W-1:0]   out_index;
  logic [COLOR_W-1:0] out_color;
  logic               out_last;
  logic               out_done;

  // The first result of an item works from its full mask, later ones from
  // the points still left over.
  always_comb begin
    cur_mask  = started ? rem : head.job.mask;
    low       = cur_mask & (~cur_mask + NPTS'(1));
    mask_left = cur_mask & ~low;
    has_point = cur_mask != '0;
    sel_x     = '0;
    sel_y     = '0;
    for (int i = 0; i < NPTS; i++) begin
      sel_x = sel_x | (low[i] ? head.job.px[i] : '0);
      sel_y = sel_y | (low[i] ? head.job.py[i] : '0);
    end
    prod = PROD_W'(sel_y) * PROD_W'(SCREEN_W) + PROD_W'(sel_x);
  end

  assign emit = head.valid && (!out_valid || pix.ready);
  assign pop  = emit && (mask_left == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      started   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        started   <= mask_left != '0;
      end else if (pix.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rem       <= mask_left;
      out_write <= has_point;
      out_index <= has_point ? prod[IDX_W-1:0] : '0;
      out_color <= has_point ? head.job.color : '0;
      out_last  <= mask_left == '0;
      out_done  <= head.job.done;
    end
  end

  assign pix.valid       = out_valid;
  assign pix.write_valid = out_write;
  assign pix.pixel_index = out_index;
  assign pix.write_color = out_color;
  assign pix.last        = out_last;
  assign pix.done_res    = out_done;

  a_nowrite_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_write |-> out_last)
    else $error("non-write result without last");

  a_started_head: assert property (@(posedge clk) disable iff (rst)
    started |-> head.valid)
    else $error("item in progress but queue is empty");

  a_started_rem: assert property (@(posedge clk) disable iff (rst)
    started |-> rem != '0)
    else $error("item in progress with no points left");

endmodule

// ===== sv/midpoint_circle_rasterizer.sv =====
// Top level of the midpoint circle rasterizer with screen clipping.
//
// Commands arrive on cmd: action start loads center, radius and color and
// is answered by one acknowledgement; action step emits the kept octant
// points of the current step as pixel writes on pix, in octant order, the
// final one flagged last. A step whose points are all off screen, and a
// step while no circle is active, give one result that writes nothing.
// done_res marks every result of the circle's last step and idle steps.
//
// The front updates the circle state at the transfer of a command and
// queues the clipped points; while pix is ready, the back turns one point
// per cycle into row * SCREEN_W + column in the output register. The
// first result passes the queue, then the output register. A step gives
// as many results as it keeps points, one to eight; starts and empty steps
// give one. The rate is set by the single output register of the back.
// A stalled pix channel holds its result; the two-entry queue fills and
// then cmd.ready drops. Synchronous reset clears the state to an idle
// circle at the origin and empties the queue and the output register.
module midpoint_circle_rasterizer
  import mcr_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  mcr_cmd_if.sink   cmd,
  mcr_pix_if.source pix
);

  logic  push;
  logic  full;
  logic  pop;
  job_t  push_job;
  head_t head;

  mcr_front u_front (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .full (full),
    .push (push),
    .job  (push_job)
  );

  mcr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .head     (head)
  );

  mcr_back u_back (
    .clk  (clk),
    .rst  (rst),
    .head (head),
    .pop  (pop),
    .pix  (pix)
  );

endmodule
